@@ rtl/core/tjaew_pkg.sv @@
// Shared types and constants for the TinyJAMBU AEAD word engine.
package tjaew_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned TagW       = 64;
  localparam int unsigned KeyHalfW   = 64;
  localparam int unsigned StepsPerRnd = 32;
  localparam int unsigned StepsShort = 128 * 5;
  localparam int unsigned StepsLong  = 128 * 8;
  localparam int unsigned RndShort   = StepsShort / StepsPerRnd;
  localparam int unsigned RndLong    = StepsLong / StepsPerRnd;
  localparam int unsigned RndW       = $clog2(RndLong);

  localparam logic [WordW-1:0] FrameNonce = 32'h0000_0010;
  localparam logic [WordW-1:0] FrameAd    = 32'h0000_0030;
  localparam logic [WordW-1:0] FrameText  = 32'h0000_0050;
  localparam logic [WordW-1:0] FrameFinal = 32'h0000_0070;

  typedef enum logic [1:0] {
    ACT_NONCE = 2'd0,
    ACT_AD    = 2'd1,
    ACT_TEXT  = 2'd2,
    ACT_FINAL = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_DECRYPT  = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  // Word 0 is the oldest word of the feedback register.
  typedef logic [3:0][WordW-1:0] fbr_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             last_of_run;
    logic             tag_mismatch;
  } res_t;

endpackage

@@ rtl/core/tjaew_if.sv @@
// Valid/ready channel interfaces: configuration, input items and results.
interface tjaew_cfg_if;
  import tjaew_pkg::*;
  logic                valid;
  logic                ready;
  reg_idx_e            reg_index;
  logic [KeyHalfW-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

interface tjaew_in_if;
  import tjaew_pkg::*;
  logic             valid;
  logic             ready;
  act_e             action;
  logic [WordW-1:0] data_word;
  logic [TagW-1:0]  expected_tag;
  modport source (output valid, output action, output data_word, output expected_tag,
                  input ready);
  modport sink   (input valid, input action, input data_word, input expected_tag,
                  output ready);
endinterface

interface tjaew_out_if;
  import tjaew_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result_word;
  logic             last_of_run;
  logic             tag_mismatch;
  modport source (output valid, output result_word, output last_of_run,
                  output tag_mismatch, input ready);
  modport sink   (input valid, input result_word, input last_of_run,
                  input tag_mismatch, output ready);
endinterface

@@ rtl/core/tjaew_round.sv @@
// One 32-step round of the TinyJAMBU nonlinear feedback register.
module tjaew_round (
  input  tjaew_pkg::fbr_t             state_i,
  input  logic [tjaew_pkg::WordW-1:0] key_word_i,
  output tjaew_pkg::fbr_t             state_o
);
  import tjaew_pkg::*;

  logic [WordW-1:0] tap_a, tap_b, tap_c, tap_d, fb;

  // Taps 47, 70, 85 and 91 of the 128-bit register, 32 at a time.
  assign tap_a = {state_i[2][14:0], state_i[1][31:15]};
  assign tap_b = {state_i[3][5:0],  state_i[2][31:6]};
  assign tap_c = {state_i[3][20:0], state_i[2][31:21]};
  assign tap_d = {state_i[3][26:0], state_i[2][31:27]};
  assign fb    = state_i[0] ^ tap_a ^ ~(tap_b & tap_c) ^ tap_d ^ key_word_i;

  assign state_o = {fb, state_i[3], state_i[2], state_i[1]};

endmodule

@@ rtl/core/tinyjambu_aead_word_engine_top.sv @@
// Top level of the TinyJAMBU-128 AEAD word engine.
//
// TinyJAMBU-128 engine working one 32-bit word per input beat. The 128-bit
// key and the decrypt flag sit in configuration registers (index 0 key words
// zero/one, index 1 key words two/three, index 2 decrypt mode); write them
// only while the engine is idle. A shared round unit advances the feedback
// register 32 steps per cycle. Associated data and nonce words run a
// 640-step absorb; the first nonce word of a run runs a 1024-step key
// setup before it. A text beat runs a 1024-step run and then hands its
// result to the output register; a finalize beat runs a 1024-step run,
// hands the first tag word over, runs the 640-step absorb and hands the
// second tag word over. Results sit in a one-beat output register, so the
// next input beat is taken while a result still waits; the engine only
// pauses when it has a new result and the output register is still full.
// Three nonce words in a row complete one nonce; a fourth starts a fresh
// initialisation, as does a nonce after any other action. tag_mismatch is
// only ever set on the second tag word of a finalize in decrypt mode.
module tinyjambu_aead_word_engine_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  tjaew_cfg_if.sink   cfg_i,
  tjaew_in_if.sink    in_i,
  tjaew_out_if.source out_o
);
  import tjaew_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } state_e;

  typedef enum logic [1:0] {
    PH_KEYSETUP,
    PH_MAIN,
    PH_TAG2
  } phase_e;

  // Configuration
  logic [KeyHalfW-1:0] key_low_q, key_high_q;
  logic                decrypt_q;

  // Control
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [1:0]      nonce_idx_q, nonce_idx_d;
  fbr_t            fbr_q, fbr_d;
  logic            out_vld_q, out_vld_d;
  logic            lo_ok_q, lo_ok_d;

  // Beat payload and pending result
  act_e             act_q;
  logic [WordW-1:0] word_q;
  logic [TagW-1:0]  exp_q;
  res_t             pend_q, pend_d;
  res_t             out_q;

  logic             in_acc, cfg_acc, out_free, out_load;
  logic             run_long, rnd_last;
  logic [WordW-1:0] key_word, plain, res_word;
  fbr_t             fbr_rnd;

  assign in_acc   = in_i.valid & in_i.ready;
  assign cfg_acc  = cfg_i.valid & cfg_i.ready;
  assign out_free = ~out_vld_q | out_o.ready;
  assign out_load = (state_q == ST_PUSH) & out_free;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid        = out_vld_q;
  assign out_o.result_word  = out_q.result_word;
  assign out_o.last_of_run  = out_q.last_of_run;
  assign out_o.tag_mismatch = out_q.tag_mismatch;

  // Key schedule: word n mod 4 on round n, rounds counted from each run start
  always_comb begin
    case (rnd_q[1:0])
      2'd0:    key_word = key_low_q[WordW-1:0];
      2'd1:    key_word = key_low_q[KeyHalfW-1:WordW];
      2'd2:    key_word = key_high_q[WordW-1:0];
      default: key_word = key_high_q[KeyHalfW-1:WordW];
    endcase
  end

  tjaew_round u_round (
    .state_i    (fbr_q),
    .key_word_i (key_word),
    .state_o    (fbr_rnd)
  );

  // Long runs: key setup, and the main run of text and finalize beats
  assign run_long = (phase_q == PH_KEYSETUP) |
                    ((phase_q == PH_MAIN) & ((act_q == ACT_TEXT) | (act_q == ACT_FINAL)));
  assign rnd_last = run_long ? (rnd_q == RndW'(RndLong - 1)) : (rnd_q == RndW'(RndShort - 1));

  assign res_word = fbr_rnd[2] ^ word_q;
  assign plain    = decrypt_q ? res_word : word_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    rnd_d       = rnd_q;
    nonce_idx_d = nonce_idx_q;
    fbr_d       = fbr_q;
    lo_ok_d     = lo_ok_q;
    pend_d      = pend_q;
    out_vld_d   = out_vld_q;

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          rnd_d   = '0;
          phase_d = PH_MAIN;
          case (in_i.action)
            ACT_NONCE: begin
              nonce_idx_d = (nonce_idx_q >= 2'd2) ? 2'd0 : nonce_idx_q + 2'd1;
              if (nonce_idx_q == 2'd0) begin
                fbr_d   = '0;
                phase_d = PH_KEYSETUP;
              end else begin
                fbr_d[1] = fbr_q[1] ^ FrameNonce;
              end
            end
            ACT_AD: begin
              nonce_idx_d = 2'd0;
              fbr_d[1]    = fbr_q[1] ^ FrameAd;
            end
            ACT_TEXT: begin
              nonce_idx_d = 2'd0;
              fbr_d[1]    = fbr_q[1] ^ FrameText;
            end
            default: begin
              nonce_idx_d = 2'd0;
              fbr_d[1]    = fbr_q[1] ^ FrameFinal;
            end
          endcase
        end
      end

      ST_RUN: begin
        fbr_d = fbr_rnd;
        rnd_d = rnd_q + RndW'(1);
        if (rnd_last) begin
          rnd_d = '0;
          case (phase_q)
            PH_KEYSETUP: begin
              fbr_d[1] = fbr_rnd[1] ^ FrameNonce;
              phase_d  = PH_MAIN;
            end
            PH_MAIN: begin
              case (act_q)
                ACT_TEXT: begin
                  fbr_d[3] = fbr_rnd[3] ^ plain;
                  pend_d   = '{result_word: res_word, last_of_run: 1'b1,
                               tag_mismatch: 1'b0};
                  state_d  = ST_PUSH;
                end
                ACT_FINAL: begin
                  lo_ok_d = (fbr_rnd[2] == exp_q[WordW-1:0]);
                  pend_d  = '{result_word: fbr_rnd[2], last_of_run: 1'b0,
                              tag_mismatch: 1'b0};
                  state_d = ST_PUSH;
                end
                default: begin
                  // nonce and associated data: absorb the word, done
                  fbr_d[3] = fbr_rnd[3] ^ word_q;
                  state_d  = ST_IDLE;
                end
              endcase
            end
            default: begin
              pend_d = '{result_word: fbr_rnd[2], last_of_run: 1'b1,
                         tag_mismatch: decrypt_q &
                           ~(lo_ok_q & (fbr_rnd[2] == exp_q[TagW-1:WordW]))};
              state_d = ST_PUSH;
            end
          endcase
        end
      end

      ST_PUSH: begin
        if (out_free) begin
          if ((act_q == ACT_FINAL) && (phase_q == PH_MAIN)) begin
            // second tag word: re-frame and run the short absorb
            fbr_d[1] = fbr_q[1] ^ FrameFinal;
            phase_d  = PH_TAG2;
            rnd_d    = '0;
            state_d  = ST_RUN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MAIN;
      rnd_q       <= '0;
      nonce_idx_q <= 2'd0;
      fbr_q       <= '0;
      lo_ok_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rnd_q       <= rnd_d;
      nonce_idx_q <= nonce_idx_d;
      fbr_q       <= fbr_d;
      lo_ok_q     <= lo_ok_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= in_i.action;
      word_q <= in_i.data_word;
      exp_q  <= in_i.expected_tag;
    end
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  // Configuration registers; a write to an unused index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      decrypt_q  <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_i.reg_index)
        REG_KEY_LOW:  key_low_q  <= cfg_i.wdata;
        REG_KEY_HIGH: key_high_q <= cfg_i.wdata;
        REG_DECRYPT:  decrypt_q  <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Checks
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN))
    else $error("engine not running after an accepted beat");

  a_rnd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rnd_q <= RndW'(RndLong - 1)))
    else $error("round counter out of range");

  a_mismatch_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.tag_mismatch) |-> (out_q.last_of_run && decrypt_q))
    else $error("tag mismatch flagged on a non-final result");

  a_nonce_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonce_idx_q != 2'd3)
    else $error("nonce word counter escaped its range");

endmodule
